// File: src/sfs_pkg.sv
// sfs_pkg: shared types, field widths, operation codes and register indexes
// for the static friction sweep sequencer. no dependencies.
`default_nettype none

package sfs_pkg;

    localparam int PCT_W      = 7;
    localparam int SPL_W      = 5;
    localparam int DWELL_W    = 10;
    localparam int MAG_W      = 16;
    localparam int DRV_W      = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // operation codes of an input transaction
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LVL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_INCR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PCT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;

    // register values after reset
    localparam logic [PCT_W-1:0]   RST_FIRST_LVL = 7'd5;
    localparam logic [PCT_W-1:0]   RST_LVL_INCR  = 7'd1;
    localparam logic [PCT_W-1:0]   RST_MAX_PCT   = 7'd60;
    localparam logic [SPL_W-1:0]   RST_SAMPLES   = 5'd5;
    localparam logic [DWELL_W-1:0] RST_DWELL     = 10'd100;
    localparam logic [MAG_W-1:0]   RST_THRESHOLD = 16'd50;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef logic [MAG_W-1:0] t_mag;

    // what one sort cell hands to its right neighbor
    typedef struct packed {
        logic gt;
        t_mag value;
    } t_link;

    // insertion command broadcast to every cell
    typedef struct packed {
        logic insert;
        t_mag mag;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/sfs_ifs.sv
// sfs_ifs: valid/ready channel interfaces for input, result and configuration
// transactions. depends on sfs_pkg.
`default_nettype none

interface sfs_in_if import sfs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [MAG_W-1:0] bemf_sample;

    modport source (output valid, operation, bemf_sample, input ready);
    modport sink   (input valid, operation, bemf_sample, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DRV_W-1:0] drive_command;
    logic                    brake_motor;
    logic                    reset_encoder;
    logic                    sample_request;
    logic                    done_res;
    logic [PCT_W-1:0]        ks_positive;
    logic [PCT_W-1:0]        ks_negative;
    logic [PCT_W-1:0]        ks_average;
    logic                    measured;

    modport source (output valid, drive_command, brake_motor, reset_encoder,
                    sample_request, done_res, ks_positive, ks_negative,
                    ks_average, measured, input ready);
    modport sink   (input valid, drive_command, brake_motor, reset_encoder,
                    sample_request, done_res, ks_positive, ks_negative,
                    ks_average, measured, output ready);
endinterface

interface sfs_cfg_if import sfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// File: src/sfs_sort_cell.sv
// sfs_sort_cell: one slot of the sorted magnitude list. takes its left
// neighbor's value on insertion when that one is larger. depends on sfs_pkg.
`default_nettype none

module sfs_sort_cell import sfs_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_in_use,
    input  wire logic      i_at_end,
    input  wire t_link     i_left,
    output t_link          o_link
);

    t_mag r_value;
    t_mag n_value;
    logic own_gt;

    assign own_gt = i_in_use && (r_value > i_ctl.mag);

    always_comb begin
        n_value = r_value;
        if (i_ctl.insert) begin
            if (i_left.gt) begin
                n_value = i_left.value;
            end else if (i_at_end || own_gt) begin
                n_value = i_ctl.mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.gt    = own_gt;
    assign o_link.value = r_value;

endmodule

`default_nettype wire

// File: src/sfs_sort_chain.sv
// sfs_sort_chain: row of sort cells holding the magnitudes of the current
// level in ascending order, plus the median read port. depends on sfs_pkg.
`default_nettype none

module sfs_sort_chain import sfs_pkg::*; #(
    parameter int MAX_SAMPLES = 16,
    parameter int CW = $clog2(MAX_SAMPLES + 1),
    parameter int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  wire logic          i_clk,
    input  wire t_cell_ctl     i_ctl,
    input  wire logic [CW-1:0] i_count,
    input  wire logic [IW-1:0] i_med_idx,
    output t_mag               o_median
);

    t_link w_link [MAX_SAMPLES+1];
    t_mag  w_val  [MAX_SAMPLES];

    assign w_link[0] = '{gt: 1'b0, value: '0};

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        sfs_sort_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (i_ctl),
            .i_in_use (CW'(g) < i_count),
            .i_at_end (CW'(g) == i_count),
            .i_left   (w_link[g]),
            .o_link   (w_link[g+1])
        );
        assign w_val[g] = w_link[g+1].value;
    end

    assign o_median = w_val[i_med_idx];

endmodule

`default_nettype wire

// File: src/static_friction_sweep_sequencer_core.sv
// static_friction_sweep_sequencer_core: brake/settle/sweep sequencer with a
// sorted back-EMF cell chain. depends on sfs_pkg, sfs_ifs, sfs_sort_chain.
// an accepted input transaction is registered in the staging register and
// executes from there into the result register, waiting while that is held.
// throughput: one input transaction per cycle while the result register
// drains; each item executes out of the staging register.
// reset (synchronous, active low) clears the sequencer, the channel state and
// restores the configuration defaults; the sort cells are not cleared.
`default_nettype none

module static_friction_sweep_sequencer_core import sfs_pkg::*; #(
    parameter int MAX_SAMPLES          = 16,
    parameter int SETTLE_TICKS         = 200,
    parameter int SAMPLE_SPACING_TICKS = 5
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sfs_in_if.sink    i_in_chan,
    sfs_out_if.source o_out_chan,
    sfs_cfg_if.sink   i_cfg_chan
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW = $clog2(SETTLE_TICKS + 1);
    localparam int PW = $clog2(SAMPLE_SPACING_TICKS + 1);
    localparam int TA = (SW > DWELL_W) ? SW : DWELL_W;
    localparam int TW = (TA > PW) ? TA : PW;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SETTLE = 3'd1;
    localparam logic [2:0] PH_DWELL  = 3'd2;
    localparam logic [2:0] PH_WAIT   = 3'd3;
    localparam logic [2:0] PH_SPACE  = 3'd4;
    localparam logic [2:0] PH_MID    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // configuration
    logic [PCT_W-1:0]   r_first_lvl;
    logic [PCT_W-1:0]   r_lvl_incr;
    logic [PCT_W-1:0]   r_max_pct;
    logic [SPL_W-1:0]   r_samples;
    logic [DWELL_W-1:0] r_dwell;
    t_mag               r_threshold;

    // input staging
    logic             r_busy;
    logic [OP_W-1:0]  r_op;
    logic [MAG_W-1:0] r_raw;

    // sequencer state
    logic [2:0]       r_phase,  n_phase;
    logic             r_rev,    n_rev;
    logic [PCT_W-1:0] r_level,  n_level;
    logic [TW-1:0]    r_timer,  n_timer;
    logic [CW-1:0]    r_taken,  n_taken;
    logic [PCT_W-1:0] r_fwd,    n_fwd;
    logic [PCT_W-1:0] r_revres, n_revres;

    // result register
    logic                    r_out_valid;
    logic signed [DRV_W-1:0] r_drive;
    logic                    r_brake;
    logic                    r_enc;
    logic                    r_req;
    logic                    r_done;
    logic [PCT_W-1:0]        r_ks_pos;
    logic [PCT_W-1:0]        r_ks_neg;
    logic [PCT_W-1:0]        r_ks_avg;
    logic                    r_measured;

    logic                    emit;
    logic signed [DRV_W-1:0] res_drive;
    logic                    res_brake;
    logic                    res_enc;
    logic                    res_req;
    logic                    res_done;
    logic [PCT_W-1:0]        res_ks_pos;
    logic [PCT_W-1:0]        res_ks_neg;
    logic [PCT_W-1:0]        res_ks_avg;
    logic                    res_measured;

    logic          out_free;
    logic          go;
    logic          in_accept;
    logic [CW-1:0] nsamp;
    logic [IW-1:0] med_idx;
    t_mag          median;
    t_mag          mag;
    t_cell_ctl     cell_ctl;
    logic          room;

    assign out_free  = !r_out_valid || o_out_chan.ready;
    assign go        = r_busy && out_free;
    assign in_accept = i_in_chan.valid && i_in_chan.ready;
    assign i_in_chan.ready  = !r_busy || go;
    assign i_cfg_chan.ready = 1'b1;

    // effective sample count, clamped to 1..MAX_SAMPLES
    always_comb begin
        if (r_samples == '0) begin
            nsamp = CW'(1);
        end else if (32'(r_samples) > 32'(MAX_SAMPLES)) begin
            nsamp = CW'(MAX_SAMPLES);
        end else begin
            nsamp = CW'(r_samples);
        end
    end

    assign med_idx = IW'(nsamp >> 1);
    assign mag     = r_raw[MAG_W-1] ? (~r_raw + 1'b1) : r_raw;
    assign room    = r_taken < CW'(MAX_SAMPLES);

    assign cell_ctl.insert = go && (r_op == OP_SAMPLE) && (r_phase == PH_WAIT) && room;
    assign cell_ctl.mag    = mag;

    sfs_sort_chain #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .IW          (IW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (cell_ctl),
        .i_count   (r_taken),
        .i_med_idx (med_idx),
        .o_median  (median)
    );

    always_comb begin
        logic [TW-1:0]    t_inc;
        logic             start_sweep;
        logic             do_eval;
        logic             hit;
        logic             fail;
        logic [PCT_W-1:0] cand;
        logic [PCT_W-1:0] end_val;
        logic [PCT_W-1:0] step_eff;
        logic [PCT_W:0]   sum;
        logic [PCT_W-1:0] dmag;

        n_phase  = r_phase;
        n_rev    = r_rev;
        n_level  = r_level;
        n_timer  = r_timer;
        n_taken  = r_taken;
        n_fwd    = r_fwd;
        n_revres = r_revres;

        emit         = 1'b0;
        res_drive    = '0;
        res_brake    = 1'b0;
        res_enc      = 1'b0;
        res_req      = 1'b0;
        res_done     = 1'b0;
        res_ks_pos   = '0;
        res_ks_neg   = '0;
        res_ks_avg   = '0;
        res_measured = 1'b0;

        t_inc       = r_timer + 1'b1;
        start_sweep = 1'b0;
        do_eval     = 1'b0;
        hit         = 1'b0;
        fail        = 1'b0;
        cand        = r_first_lvl;
        end_val     = '0;
        step_eff    = (r_lvl_incr == '0) ? PCT_W'(1) : r_lvl_incr;
        sum         = {1'b0, r_level} + {1'b0, step_eff};
        dmag        = '0;

        case (r_op)
            OP_START: begin
                n_phase   = PH_SETTLE;
                n_rev     = 1'b0;
                n_level   = '0;
                n_timer   = '0;
                n_taken   = '0;
                n_fwd     = '0;
                n_revres  = '0;
                res_brake = 1'b1;
                emit      = 1'b1;
            end
            OP_TICK: begin
                case (r_phase)
                    PH_SETTLE, PH_MID: begin
                        n_timer = t_inc;
                        if (t_inc >= TW'(SETTLE_TICKS)) begin
                            res_enc     = (r_phase == PH_SETTLE);
                            start_sweep = 1'b1;
                            emit        = 1'b1;
                        end
                    end
                    PH_DWELL: begin
                        n_timer = t_inc;
                        if (t_inc >= TW'(r_dwell)) begin
                            res_req = 1'b1;
                            n_phase = PH_WAIT;
                            emit    = 1'b1;
                        end
                    end
                    PH_SPACE: begin
                        n_timer = t_inc;
                        if (t_inc >= TW'(SAMPLE_SPACING_TICKS)) begin
                            if (r_taken < nsamp) begin
                                res_req = 1'b1;
                                n_phase = PH_WAIT;
                            end else begin
                                do_eval = 1'b1;
                            end
                            emit = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_SAMPLE: begin
                if (r_phase == PH_WAIT) begin
                    if (room) begin
                        n_taken = r_taken + 1'b1;
                    end
                    n_timer = '0;
                    n_phase = PH_SPACE;
                end
            end
            default: begin
            end
        endcase

        if (start_sweep) begin
            cand    = r_first_lvl;
            fail    = r_first_lvl > r_max_pct;
            n_level = r_first_lvl;
        end else if (do_eval) begin
            hit  = median >= r_threshold;
            cand = sum[PCT_W-1:0];
            fail = sum > {1'b0, r_max_pct};
        end

        if (start_sweep || do_eval) begin
            if (hit || fail) begin
                // sweep over: brake and record the breakaway level
                end_val   = hit ? r_level : '0;
                res_drive = '0;
                res_brake = 1'b1;
                n_timer   = '0;
                if (!r_rev) begin
                    n_fwd   = end_val;
                    n_rev   = 1'b1;
                    n_phase = PH_MID;
                end else begin
                    n_revres     = end_val;
                    n_phase      = PH_DONE;
                    res_done     = 1'b1;
                    res_ks_pos   = r_fwd;
                    res_ks_neg   = end_val;
                    res_ks_avg   = PCT_W'(({1'b0, r_fwd} + {1'b0, end_val}) >> 1);
                    res_measured = (r_fwd != '0) && (end_val != '0);
                end
            end else begin
                // next drive level
                n_level   = cand;
                dmag      = (cand > PCT_FULL) ? PCT_FULL : cand;
                res_drive = r_rev ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
                n_taken   = '0;
                n_timer   = '0;
                if (r_dwell == '0) begin
                    res_req = 1'b1;
                    n_phase = PH_WAIT;
                end else begin
                    n_phase = PH_DWELL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_lvl <= RST_FIRST_LVL;
            r_lvl_incr  <= RST_LVL_INCR;
            r_max_pct   <= RST_MAX_PCT;
            r_samples   <= RST_SAMPLES;
            r_dwell     <= RST_DWELL;
            r_threshold <= RST_THRESHOLD;
        end else if (i_cfg_chan.valid && i_cfg_chan.ready) begin
            case (i_cfg_chan.reg_index)
                CFG_FIRST_LVL: r_first_lvl <= i_cfg_chan.wr_data[PCT_W-1:0];
                CFG_LVL_INCR:  r_lvl_incr  <= i_cfg_chan.wr_data[PCT_W-1:0];
                CFG_MAX_PCT:   r_max_pct   <= i_cfg_chan.wr_data[PCT_W-1:0];
                CFG_SAMPLES:   r_samples   <= i_cfg_chan.wr_data[SPL_W-1:0];
                CFG_DWELL:     r_dwell     <= i_cfg_chan.wr_data[DWELL_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_chan.wr_data[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_accept) begin
            r_busy <= 1'b1;
        end else if (go) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_in_chan.operation;
            r_raw <= i_in_chan.bemf_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_rev    <= 1'b0;
            r_level  <= '0;
            r_timer  <= '0;
            r_taken  <= '0;
            r_fwd    <= '0;
            r_revres <= '0;
        end else if (go) begin
            r_phase  <= n_phase;
            r_rev    <= n_rev;
            r_level  <= n_level;
            r_timer  <= n_timer;
            r_taken  <= n_taken;
            r_fwd    <= n_fwd;
            r_revres <= n_revres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_drive    <= res_drive;
            r_brake    <= res_brake;
            r_enc      <= res_enc;
            r_req      <= res_req;
            r_done     <= res_done;
            r_ks_pos   <= res_ks_pos;
            r_ks_neg   <= res_ks_neg;
            r_ks_avg   <= res_ks_avg;
            r_measured <= res_measured;
        end
    end

    assign o_out_chan.valid          = r_out_valid;
    assign o_out_chan.drive_command  = r_drive;
    assign o_out_chan.brake_motor    = r_brake;
    assign o_out_chan.reset_encoder  = r_enc;
    assign o_out_chan.sample_request = r_req;
    assign o_out_chan.done_res       = r_done;
    assign o_out_chan.ks_positive    = r_ks_pos;
    assign o_out_chan.ks_negative    = r_ks_neg;
    assign o_out_chan.ks_average     = r_ks_avg;
    assign o_out_chan.measured       = r_measured;

    // a finished measurement always brakes and drops the drive
    a_done_brakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> r_brake && (r_drive == '0))
        else $error("done transaction without brake");

    // the sample count never runs past the cell chain
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= CW'(MAX_SAMPLES))
        else $error("sample count beyond chain length");

    // the measured flag needs both breakaway levels
    a_measured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_measured |-> (r_ks_pos != '0) && (r_ks_neg != '0))
        else $error("measured set with a zero breakaway level");

    // a cell insertion only happens while a sample is awaited
    a_insert_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.insert |=> (r_phase == PH_SPACE))
        else $error("insertion outside sample wait");

endmodule

`default_nettype wire

// File: verif/static_friction_sweep_sequencer_core_tb.sv
// testbench for static_friction_sweep_sequencer_core: drives start, tick and back-EMF
// transactions, predicts every result and checks them in order.
// depends on sfs_pkg, sfs_ifs and the core itself.
`default_nettype none

module static_friction_sweep_sequencer_core_tb;
    import sfs_pkg::*;

    localparam int SETTLE_TICKS  = 200;
    localparam int SPACING_TICKS = 5;
    localparam int SORT_DEPTH    = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 40000;

    localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_SETTLE, SEQ_DWELL, SEQ_WAIT, SEQ_SPACE, SEQ_MID, SEQ_DONE
    } t_seq_phase;

    typedef struct {
        logic signed [DRV_W-1:0] drive;
        logic                    brake;
        logic                    enc_clear;
        logic                    sample_req;
        logic                    done;
        logic [PCT_W-1:0]        ks_pos;
        logic [PCT_W-1:0]        ks_neg;
        logic [PCT_W-1:0]        ks_avg;
        logic                    measured;
    } t_sweep_result;

    logic i_clk;
    logic i_rst_n;

    sfs_in_if  in_chan ();
    sfs_out_if out_chan ();
    sfs_cfg_if cfg_chan ();

    static_friction_sweep_sequencer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan),
        .i_cfg_chan (cfg_chan)
    );

    // predicted configuration and sequencer state
    logic [PCT_W-1:0]   cfg_start;
    logic [PCT_W-1:0]   cfg_step;
    logic [PCT_W-1:0]   cfg_max;
    logic [SPL_W-1:0]   cfg_spl;
    logic [DWELL_W-1:0] cfg_dwell;
    logic [MAG_W-1:0]   cfg_thr;

    t_seq_phase       seq_phase;
    logic             seq_reverse;
    logic [PCT_W-1:0] seq_level;
    int               seq_timer;
    int               seq_taken;
    t_mag             seq_mags [SORT_DEPTH];
    logic [PCT_W-1:0] fwd_ks;
    logic [PCT_W-1:0] rev_ks;

    t_sweep_result pending_results [$];
    int            mismatch_count = 0;
    int            useful_items = 0;
    int            cycle_count = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    bit            quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic int eff_samples();
        int n;
        n = cfg_spl;
        if (n < 1) n = 1;
        if (n > SORT_DEPTH) n = SORT_DEPTH;
        return n;
    endfunction

    function automatic void enter_level(inout t_sweep_result r);
        int m;
        m = (seq_level > PCT_FULL) ? int'(PCT_FULL) : int'(seq_level);
        r.drive = DRV_W'(seq_reverse ? -m : m);
        seq_taken = 0;
        seq_timer = 0;
        if (cfg_dwell == 0) begin
            r.sample_req = 1'b1;
            seq_phase = SEQ_WAIT;
        end else begin
            seq_phase = SEQ_DWELL;
        end
    endfunction

    function automatic void finish_sweep(input int value, inout t_sweep_result r);
        r.drive = '0;
        r.brake = 1'b1;
        seq_timer = 0;
        if (!seq_reverse) begin
            fwd_ks = PCT_W'(value);
            seq_reverse = 1'b1;
            seq_phase = SEQ_MID;
        end else begin
            rev_ks = PCT_W'(value);
            seq_phase = SEQ_DONE;
            r.done = 1'b1;
            r.ks_pos = fwd_ks;
            r.ks_neg = rev_ks;
            r.ks_avg = PCT_W'((int'(fwd_ks) + int'(rev_ks)) >> 1);
            r.measured = (fwd_ks != 0) && (rev_ks != 0);
        end
    endfunction

    // returns 1 when the transaction produces a result
    function automatic bit advance_sequencer(input logic [OP_W-1:0] op,
                                             input logic [MAG_W-1:0] sample,
                                             output t_sweep_result r, output bit ignored);
        bit   emit;
        int   n;
        int   next_level;
        int   slot;
        t_mag mag;
        r = '{default: '0};
        emit = 1'b0;
        ignored = (op == OP_UNUSED)
            || (op == OP_TICK && (seq_phase == SEQ_IDLE || seq_phase == SEQ_DONE
                                  || seq_phase == SEQ_WAIT))
            || (op == OP_SAMPLE && seq_phase != SEQ_WAIT);
        case (op)
            OP_START: begin
                seq_phase = SEQ_SETTLE;
                seq_reverse = 1'b0;
                seq_level = '0;
                seq_timer = 0;
                seq_taken = 0;
                fwd_ks = '0;
                rev_ks = '0;
                r.brake = 1'b1;
                emit = 1'b1;
            end
            OP_TICK: begin
                if (seq_phase == SEQ_SETTLE || seq_phase == SEQ_MID) begin
                    seq_timer++;
                    if (seq_timer >= SETTLE_TICKS) begin
                        if (seq_phase == SEQ_SETTLE) r.enc_clear = 1'b1;
                        seq_level = cfg_start;
                        if (seq_level > cfg_max) finish_sweep(0, r);
                        else enter_level(r);
                        emit = 1'b1;
                    end
                end else if (seq_phase == SEQ_DWELL) begin
                    seq_timer++;
                    if (seq_timer >= cfg_dwell) begin
                        r.sample_req = 1'b1;
                        seq_phase = SEQ_WAIT;
                        emit = 1'b1;
                    end
                end else if (seq_phase == SEQ_SPACE) begin
                    seq_timer++;
                    if (seq_timer >= SPACING_TICKS) begin
                        n = eff_samples();
                        if (seq_taken < n) begin
                            r.sample_req = 1'b1;
                            seq_phase = SEQ_WAIT;
                        end else if (seq_mags[(n >> 1) % SORT_DEPTH] >= cfg_thr) begin
                            finish_sweep(seq_level, r);
                        end else begin
                            next_level = int'(seq_level) + ((cfg_step == 0) ? 1 : int'(cfg_step));
                            if (next_level > cfg_max) begin
                                finish_sweep(0, r);
                            end else begin
                                seq_level = PCT_W'(next_level);
                                enter_level(r);
                            end
                        end
                        emit = 1'b1;
                    end
                end
            end
            OP_SAMPLE: begin
                if (seq_phase == SEQ_WAIT) begin
                    // -32768 has magnitude 32768, still 16 bits
                    mag = sample[MAG_W-1] ? t_mag'(17'h10000 - {1'b0, sample}) : sample;
                    slot = seq_taken;
                    if (slot < SORT_DEPTH) begin
                        while (slot > 0 && seq_mags[slot-1] > mag) begin
                            seq_mags[slot] = seq_mags[slot-1];
                            slot--;
                        end
                        seq_mags[slot] = mag;
                        seq_taken++;
                    end
                    seq_timer = 0;
                    seq_phase = SEQ_SPACE;
                end
            end
            default: ;
        endcase
        return emit;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result sink with random stalls and long hold-offs on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_chan.ready <= 1'b0;
            end else begin
                out_chan.ready <= quiet || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sweep_result want;
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("drive_command", int'(out_chan.drive_command), int'(want.drive));
                check_field("brake_motor", out_chan.brake_motor, want.brake);
                check_field("reset_encoder", out_chan.reset_encoder, want.enc_clear);
                check_field("sample_request", out_chan.sample_request, want.sample_req);
                check_field("done_res", out_chan.done_res, want.done);
                check_field("ks_positive", out_chan.ks_positive, want.ks_pos);
                check_field("ks_negative", out_chan.ks_negative, want.ks_neg);
                check_field("ks_average", out_chan.ks_average, want.ks_avg);
                check_field("measured", out_chan.measured, want.measured);
            end
        end
    end

    // valid is left high after a transaction; whoever pauses the input lowers it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [MAG_W-1:0] sample);
        t_sweep_result r;
        bit ignored;
        while (!quiet && $urandom_range(0, 99) < 22) begin
            in_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.operation <= op;
        in_chan.bemf_sample <= sample;
        do @(posedge i_clk); while (!in_chan.ready);
        if (advance_sequencer(op, sample, r, ignored)) pending_results = {pending_results, r};
        if (!ignored) useful_items++;
    endtask

    task automatic wait_drain();
        in_chan.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value,
                                  input int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        // junk above the register width must be dropped
        if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
            data = data | (CFG_DATA_W'($urandom) << width);
        cfg_chan.valid <= 1'b1;
        cfg_chan.reg_index <= idx;
        cfg_chan.wr_data <= data;
        do @(posedge i_clk); while (!cfg_chan.ready);
        case (idx)
            CFG_FIRST_LVL: cfg_start = data[PCT_W-1:0];
            CFG_LVL_INCR:  cfg_step  = data[PCT_W-1:0];
            CFG_MAX_PCT:   cfg_max   = data[PCT_W-1:0];
            CFG_SAMPLES:   cfg_spl   = data[SPL_W-1:0];
            CFG_DWELL:     cfg_dwell = data[DWELL_W-1:0];
            CFG_THRESHOLD: cfg_thr   = data[MAG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input int first_lvl, input int lvl_incr, input int max_pct,
                                    input int spl, input int dwell, input int thr);
        wait_drain();
        write_register(CFG_SPARE_LO, $urandom, CFG_DATA_W);
        write_register(CFG_FIRST_LVL, first_lvl, PCT_W);
        write_register(CFG_LVL_INCR, lvl_incr, PCT_W);
        write_register(CFG_MAX_PCT, max_pct, PCT_W);
        write_register(CFG_SAMPLES, spl, SPL_W);
        write_register(CFG_DWELL, dwell, DWELL_W);
        write_register(CFG_THRESHOLD, thr, MAG_W);
        write_register(CFG_SPARE_HI, $urandom, CFG_DATA_W);
        cfg_chan.valid <= 1'b0;
    endtask

    // back-EMF values clustered around the threshold, plus the extremes
    function automatic logic [MAG_W-1:0] pick_sample();
        int m;
        case ($urandom_range(0, 5))
            0: return MAG_W'($urandom);
            1: m = cfg_thr;
            2: m = (cfg_thr == 0) ? 0 : int'(cfg_thr) - 1;
            3: m = $urandom_range(0, cfg_thr);
            4: return 16'h8000;
            default: m = ($urandom_range(0, 3) == 0) ? 32767
                                                      : $urandom_range(0, 2 * cfg_thr + 1);
        endcase
        if (m >= 32768) return 16'h8000;
        return $urandom_range(0, 1) ? MAG_W'(-m) : MAG_W'(m);
    endfunction

    // one start, then ticks and samples as the sequencer asks for them, plus random noise items
    task automatic run_sweeps(input int noise_pct, input int budget);
        int sent;
        sent = 0;
        send_item(OP_START, MAG_W'($urandom));
        while (seq_phase != SEQ_DONE && sent < budget) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 4))
                    0: send_item(($urandom_range(0, 99) == 0) ? OP_START : OP_TICK,
                                 MAG_W'($urandom));
                    1: send_item(OP_UNUSED, MAG_W'($urandom));
                    2: send_item(OP_SAMPLE, MAG_W'($urandom));
                    default: send_item(OP_TICK, MAG_W'($urandom));
                endcase
            end else if (seq_phase == SEQ_WAIT) begin
                send_item(OP_SAMPLE, pick_sample());
            end else begin
                send_item(OP_TICK, MAG_W'($urandom));
            end
            sent++;
        end
    endtask

    task automatic test_ignored_ops();
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'h7FFF);
        send_item(OP_SAMPLE, 16'h8000);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_START, 16'h0000);
        send_item(OP_UNUSED, 16'h5555);
        send_item(OP_SAMPLE, 16'hAAAA);
        send_item(OP_TICK, 16'h8001);
        // restart while busy
        send_item(OP_START, 16'hFFFF);
        send_item(OP_TICK, 16'h0001);
    endtask

    task automatic test_reset_values();
        quiet = 1'b1;
        // settle, dwell and the first level's samples up to its evaluation
        run_sweeps(0, 330);
        quiet = 1'b0;
    endtask

    task automatic test_extreme_settings();
        // levels above 100 with saturated drive, zero step, zero samples, zero dwell
        program_settings(101, 0, 127, 0, 0, 0);
        run_sweeps(0, 450);
        // done state ignores ticks and samples
        send_item(OP_TICK, MAG_W'($urandom));
        send_item(OP_SAMPLE, 16'h8000);
        // sample count above the chain length, widest step
        program_settings(0, 127, 127, 31, 1, 1);
        run_sweeps(0, 300);
    endtask

    task automatic test_output_stall();
        hold_requests++;
        repeat (48) begin
            if ($urandom_range(0, 3) == 0) send_item(OP_TICK, MAG_W'($urandom));
            else send_item(OP_START, MAG_W'($urandom));
        end
    endtask

    task automatic test_random_sweeps();
        int base;
        int st_pct;
        int mx_pct;
        base = useful_items;
        while (useful_items - base < 200) begin
            st_pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 30);
            mx_pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                 : st_pct + $urandom_range(0, 12);
            if (mx_pct > 127) mx_pct = 127;
            program_settings(st_pct,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6),
                mx_pct,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5),
                ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400));
            run_sweeps(8, 220);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_chan.valid <= 1'b0;
        in_chan.operation <= OP_TICK;
        in_chan.bemf_sample <= '0;
        cfg_chan.valid <= 1'b0;
        cfg_chan.reg_index <= CFG_FIRST_LVL;
        cfg_chan.wr_data <= '0;

        cfg_start = RST_FIRST_LVL;
        cfg_step = RST_LVL_INCR;
        cfg_max = RST_MAX_PCT;
        cfg_spl = RST_SAMPLES;
        cfg_dwell = RST_DWELL;
        cfg_thr = RST_THRESHOLD;
        seq_phase = SEQ_IDLE;
        seq_reverse = 1'b0;
        seq_level = '0;
        seq_timer = 0;
        seq_taken = 0;
        fwd_ks = '0;
        rev_ks = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_ops();
        test_reset_values();
        test_extreme_settings();
        test_output_stall();
        test_random_sweeps();

        wait_drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/sfs_pkg.sv
src/sfs_ifs.sv
src/sfs_sort_cell.sv
src/sfs_sort_chain.sv
src/static_friction_sweep_sequencer_core.sv
verif/static_friction_sweep_sequencer_core_tb.sv
